// ----- design/mi3_pkg.sv -----
// Shared widths and types for the 3x3 matrix inverse pipeline.
// No dependencies; imported by mi3_div and matrix_inverse_3x3_top.
package mi3_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int HW = NW - W;
  localparam int XW = ((DW > HW) ? DW : HW) + 1;
  localparam int TW = 9 * W;
  localparam int UW = 2;
  localparam int LAT_DIV = W + 1;
  localparam int NV = 5 + LAT_DIV + 1;

  localparam int USER_SINGULAR  = 0;
  localparam int USER_SATURATED = 1;

  typedef logic signed [W-1:0]  ent_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [DW-1:0] det_t;

endpackage

// ----- design/mi3_div.sv -----
// Pipelined restoring divider lane: magnitude quotient of one inverse entry.
// Depends on mi3_pkg; one step per stage, W+1 stages, one beat per cycle while en is high.
module mi3_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [mi3_pkg::NW-1:0]   num_i,
  input  logic [mi3_pkg::DW-1:0]   den_i,
  input  logic                     neg_i,
  output logic [mi3_pkg::W-1:0]    q_o,
  output logic                     neg_o,
  output logic                     ovf_o
);
  import mi3_pkg::*;

  logic [XW-1:0] rem_r [0:W];
  logic [XW-1:0] den_r [0:W];
  logic [W-1:0]  lo_r  [0:W];
  logic [W-1:0]  q_r   [0:W];
  logic          neg_r [0:W];
  logic          ovf_r [0:W];

  logic [XW-1:0] rem_nxt [1:W];
  logic [W-1:0]  q_nxt   [1:W];
  logic [XW-1:0] hi;
  logic [XW-1:0] den_x;

  assign hi    = XW'(num_i[NW-1:W]);
  assign den_x = XW'(den_i);

  always_comb begin
    logic [XW-1:0] t;
    logic          ge;
    for (int k = 1; k <= W; k++) begin
      t  = {rem_r[k-1][XW-2:0], lo_r[k-1][W-1]};
      ge = (t >= den_r[k-1]);
      rem_nxt[k] = ge ? (t - den_r[k-1]) : t;
      q_nxt[k]   = {q_r[k-1][W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi;
      den_r[0] <= den_x;
      lo_r[0]  <= num_i[W-1:0];
      q_r[0]   <= '0;
      neg_r[0] <= neg_i;
      ovf_r[0] <= (hi >= den_x);
      for (int k = 1; k <= W; k++) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_r[k-1];
        lo_r[k]  <= {lo_r[k-1][W-2:0], 1'b0};
        q_r[k]   <= q_nxt[k];
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign q_o   = q_r[W];
  assign neg_o = neg_r[W];
  assign ovf_o = ovf_r[W];

endmodule

// ----- design/matrix_inverse_3x3_top.sv -----
// 3x3 matrix inverse by adjugate, signed fixed point, streaming in and out.
// Depends on mi3_pkg and mi3_div.
//
// One matrix beat is accepted every cycle unless the output stalls, and its
// inverse passes through 18 products, cofactors, split determinant
// products, determinant sum, magnitudes, then one quotient bit per stage in
// nine parallel divider lanes, and a saturation stage that is the output
// register. The pipeline stalls as a whole only while a result waits on
// out_tready. Entries are truncated toward zero and clipped to range; a zero
// determinant gives zero entries with the singular flag set.
module matrix_inverse_3x3_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2
  input  logic [mi3_pkg::TW-1:0]  in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2, inv_r2c0,
  // inv_r2c1, inv_r2c2
  output logic [mi3_pkg::TW-1:0]  out_tdata,
  // singular, saturated
  output logic [mi3_pkg::UW-1:0]  out_tuser
);
  import mi3_pkg::*;

  localparam logic [W-1:0] QHALF = {1'b1, {(W-1){1'b0}}};

  logic          adv;
  logic          vld_r [0:NV-1];

  ent_t          m [0:8];
  prod_t         pa_r [0:8];
  prod_t         pb_r [0:8];
  prod_t         pa_nxt [0:8];
  prod_t         pb_nxt [0:8];
  ent_t          ea_r [0:2];
  ent_t          eb_r [0:2];
  cof_t          cb_r [0:8];
  logic signed [CW-1:0] ml_r [0:2];
  logic signed [CW-1:0] mh_r [0:2];
  logic signed [CW-1:0] ml_nxt [0:2];
  logic signed [CW-1:0] mh_nxt [0:2];
  cof_t          cc_r [0:8];
  cof_t          cd_r [0:8];
  det_t          det_r;
  det_t          det_nxt;
  logic [NW-1:0] num_r [0:8];
  logic [DW-1:0] den_r;
  logic          neg_r [0:8];
  logic          dz_r;
  logic          dzl_r [0:W];

  logic [W-1:0]  q_w   [0:8];
  logic          ngq_w [0:8];
  logic          ovf_w [0:8];

  logic [TW-1:0] dout_r, dout_nxt;
  logic [UW-1:0] user_r, user_nxt;

  assign adv        = !vld_r[NV-1] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[NV-1];
  assign out_tdata  = dout_r;
  assign out_tuser  = user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NV; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int s = 1; s < NV; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) m[k] = ent_t'(in_tdata[k*W +: W]);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pa_nxt[i*3+j] = m[((j+1)%3)*3 + (i+1)%3] * m[((j+2)%3)*3 + (i+2)%3];
        pb_nxt[i*3+j] = m[((j+1)%3)*3 + (i+2)%3] * m[((j+2)%3)*3 + (i+1)%3];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ml_nxt[j] = eb_r[j] * $signed({1'b0, cb_r[j*3][W-1:0]});
      mh_nxt[j] = eb_r[j] * $signed(cb_r[j*3][CW-1:W]);
    end
    det_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      det_nxt = det_nxt + (DW'(mh_r[j]) <<< W) + DW'(ml_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        pa_r[k] <= pa_nxt[k];
        pb_r[k] <= pb_nxt[k];
        cb_r[k] <= {pa_r[k][PW-1], pa_r[k]} - {pb_r[k][PW-1], pb_r[k]};
        cc_r[k] <= cb_r[k];
        cd_r[k] <= cc_r[k];
        num_r[k] <= NW'(cd_r[k][CW-1] ? -cd_r[k] : cd_r[k]) << (2 * FRAC_BITS);
        neg_r[k] <= cd_r[k][CW-1] ^ det_r[DW-1];
      end
      for (int j = 0; j < 3; j++) begin
        ea_r[j] <= m[j];
        eb_r[j] <= ea_r[j];
        ml_r[j] <= ml_nxt[j];
        mh_r[j] <= mh_nxt[j];
      end
      det_r <= det_nxt;
      den_r <= det_r[DW-1] ? -det_r : det_r;
      dz_r  <= (det_r == '0);
      dzl_r[0] <= dz_r;
      for (int s = 1; s <= W; s++) dzl_r[s] <= dzl_r[s-1];
      dout_r <= dout_nxt;
      user_r <= user_nxt;
    end
  end

  for (genvar g = 0; g < 9; g++) begin : g_lane
    mi3_div u_div (
      .clk   (clk),
      .en    (adv),
      .num_i (num_r[g]),
      .den_i (den_r),
      .neg_i (neg_r[g]),
      .q_o   (q_w[g]),
      .neg_o (ngq_w[g]),
      .ovf_o (ovf_w[g])
    );
  end

  always_comb begin
    logic fits;
    logic any_sat;
    any_sat  = 1'b0;
    dout_nxt = '0;
    for (int k = 0; k < 9; k++) begin
      fits = !ovf_w[k] && (ngq_w[k] ? (q_w[k] <= QHALF) : (q_w[k] < QHALF));
      if (!fits) any_sat = 1'b1;
      if (dzl_r[W]) begin
        dout_nxt[k*W +: W] = '0;
      end else if (fits) begin
        dout_nxt[k*W +: W] = ngq_w[k] ? -q_w[k] : q_w[k];
      end else begin
        dout_nxt[k*W +: W] = ngq_w[k] ? QHALF : ~QHALF;
      end
    end
    user_nxt = '0;
    user_nxt[USER_SINGULAR]  = dzl_r[W];
    user_nxt[USER_SATURATED] = any_sat && !dzl_r[W];
  end

endmodule

// ----- tb/sv/matrix_inverse_3x3_top_test.sv -----
// Self-checking testbench for matrix_inverse_3x3_top: streams 3x3 Q16.16 matrices,
// predicts inverses not given in wide integer math and compares entries and flags.
// Depends on mi3_pkg and the matrix_inverse_3x3_top RTL.
`timescale 1ns / 100ps

module matrix_inverse_3x3_top_test;
  import mi3_pkg::*;

  typedef logic signed [191:0] wide_t;
  typedef struct packed {
    logic [TW-1:0] mat;
    logic          known;
    logic [TW-1:0] inv;
    logic [UW-1:0] flags;
  } row_t;
  typedef struct packed {
    logic [TW-1:0] inv;
    logic [UW-1:0] flags;
  } inv_t;

  localparam ent_t ONE  = 32'sh0001_0000;
  localparam ent_t EMAX = 32'sh7fff_ffff;
  localparam ent_t EMIN = 32'sh8000_0000;
  localparam int   N_RANDOM = 1030;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [TW-1:0] in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [TW-1:0] out_tdata;
  logic [UW-1:0] out_tuser;

  inv_t pending_inv[$];
  int   n_errors = 0;
  int   n_results = 0;
  int   n_singular = 0;
  int   n_saturated = 0;
  bit   quiet = 1'b0;
  row_t directed[$];

  matrix_inverse_3x3_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [TW-1:0] pack9(input ent_t a, b, c, d, e, f, g, h, i);
    return {i, h, g, f, e, d, c, b, a};
  endfunction

  function automatic inv_t invert_matrix(input logic [TW-1:0] m);
    wide_t e[3][3];
    wide_t cof[3][3];
    wide_t det, q, hi, lo;
    inv_t r;
    r = '0;
    hi = (wide_t'(1) <<< (W - 1)) - 1;
    lo = -hi - 1;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        e[i][j] = $signed(m[(i * 3 + j) * W +: W]);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        cof[i][j] = e[(j + 1) % 3][(i + 1) % 3] * e[(j + 2) % 3][(i + 2) % 3]
                  - e[(j + 1) % 3][(i + 2) % 3] * e[(j + 2) % 3][(i + 1) % 3];
    det = e[0][0] * cof[0][0] + e[0][1] * cof[1][0] + e[0][2] * cof[2][0];
    if (det == 0) begin
      r.flags[USER_SINGULAR] = 1'b1;
      return r;
    end
    for (int k = 0; k < 9; k++) begin
      q = (cof[k / 3][k % 3] <<< (2 * FRAC_BITS)) / det;
      if (q > hi) begin
        q = hi;
        r.flags[USER_SATURATED] = 1'b1;
      end else if (q < lo) begin
        q = lo;
        r.flags[USER_SATURATED] = 1'b1;
      end
      r.inv[k * W +: W] = q[W-1:0];
    end
    return r;
  endfunction

  function automatic ent_t rand_entry(input int kind);
    ent_t v;
    case (kind)
      0, 1: v = $urandom;
      2, 3, 4, 5: v = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      8: v = $signed($urandom_range(0, 511)) - 255;
      default: begin
        case ($urandom_range(0, 5))
          0: v = EMAX;
          1: v = EMIN;
          2: v = '0;
          3: v = 1;
          4: v = -1;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [TW-1:0] rand_matrix();
    int kind;
    ent_t m[9];
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) m[k] = rand_entry(kind);
    if (kind >= 2 && kind <= 5) begin
      m[0] += 4 * ONE;
      m[4] += 4 * ONE;
      m[8] += 4 * ONE;
    end
    if (kind == 6 || kind == 7) begin
      // make row 2 a copy of row 0 or row 0 scaled by a small factor
      for (int j = 0; j < 3; j++) begin
        m[j] = (kind == 6) ? m[j] : (m[j] >>> 3);
        m[6 + j] = (kind == 6) ? m[j] : m[j] * 3;
      end
    end
    return pack9(m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]);
  endfunction

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_matrix(input logic [TW-1:0] m, input bit known, input inv_t want);
    in_tdata  <= m;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_inv.push_back(known ? want : invert_matrix(m));
    idle_gap();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      inv_t want;
      n_results++;
      if (out_tuser[USER_SINGULAR]) n_singular++;
      if (out_tuser[USER_SATURATED]) n_saturated++;
      if (pending_inv.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat: %h / %b", out_tdata, out_tuser);
      end else begin
        want = pending_inv.pop_front();
        for (int k = 0; k < 9; k++)
          if (out_tdata[k * W +: W] !== want.inv[k * W +: W]) begin
            n_errors++;
            if (n_errors <= 10)
              $display("result %0d entry %0d: expected %h, got %h",
                       n_results, k, want.inv[k * W +: W], out_tdata[k * W +: W]);
          end
        if (out_tuser !== want.flags) begin
          n_errors++;
          if (n_errors <= 10)
            $display("result %0d flags: expected %b, got %b", n_results, want.flags, out_tuser);
        end
      end
    end
  end

  initial begin
    @(posedge clk);
    while (1) begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results pending", pending_inv.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    row_t r;
    inv_t want;
    directed.push_back('{pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b1,
                         pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 2'b00});
    directed.push_back('{'0, 1'b1, '0, 2'b01});
    directed.push_back('{{9{EMAX}}, 1'b1, '0, 2'b01});
    directed.push_back('{{9{EMIN}}, 1'b1, '0, 2'b01});
    directed.push_back('{pack9(1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1,
                         pack9(EMAX, 0, 0, 0, EMAX, 0, 0, 0, EMAX), 2'b10});
    directed.push_back('{pack9(-1, 0, 0, 0, -1, 0, 0, 0, -1), 1'b1,
                         pack9(EMIN, 0, 0, 0, EMIN, 0, 0, 0, EMIN), 2'b10});
    directed.push_back('{pack9(2 * ONE, 0, 0, 0, -4 * ONE, 0, 0, 0, ONE / 2), 1'b0, '0, '0});
    directed.push_back('{pack9(0, ONE, 0, 0, 0, ONE, ONE, 0, 0), 1'b0, '0, '0});
    directed.push_back('{pack9(EMAX, 0, 0, 0, EMIN, 0, 0, 0, EMAX), 1'b0, '0, '0});
    directed.push_back('{pack9(EMIN, EMAX, 1, -1, EMIN, EMAX, 0, 1, EMIN), 1'b0, '0, '0});
    directed.push_back('{pack9(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                               7 * ONE, 8 * ONE, 10 * ONE), 1'b0, '0, '0});
    directed.push_back('{pack9(ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE,
                               7 * ONE, 8 * ONE, 9 * ONE), 1'b0, '0, '0});
    directed.push_back('{pack9(3, 1, 0, 1, 3, 1, 0, 1, 3), 1'b0, '0, '0});
    directed.push_back('{pack9(ONE * 300, 5, -7, 11, -ONE * 200, 13, 17, -19, ONE * 100),
                         1'b0, '0, '0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[n]) begin
      r = directed[n];
      want.inv = r.inv;
      want.flags = r.flags;
      send_matrix(r.mat, r.known, want);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        // hold off until the pipeline has drained
        in_tvalid <= 1'b0;
        while (pending_inv.size() != 0) @(posedge clk);
      end
      if (n == N_RANDOM - 150) quiet = 1'b1;
      send_matrix(rand_matrix(), 1'b0, want);
    end
    in_tvalid <= 1'b0;

    while (pending_inv.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("checked %0d inverses (%0d singular, %0d saturated) from %0d directed",
             n_results, n_singular, n_saturated, directed.size());
    $display("and %0d random matrices; %0d mismatches", N_RANDOM, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
